[sv/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[sv/qpn_pkg.sv]
package qpn_pkg;

  // component count of a quaternion
  localparam int unsigned Lanes = 4;
  // signed product component width (Q2.28 with headroom)
  localparam int unsigned PW = 34;
  // magnitude of a product component
  localparam int unsigned MW = 33;
  // high and low split of the magnitude for squaring
  localparam int unsigned MLW = 17;
  localparam int unsigned MHW = MW - MLW;
  // squared magnitude and squared norm width
  localparam int unsigned SQW = 65;
  // quotient width of m^2 * 2^28 / nsq (at most 2^28)
  localparam int unsigned QW = 29;
  // square root steps, one result bit each
  localparam int unsigned SQS = 15;
  // output component width
  localparam int unsigned OW = 16;
  // default queue depth between front and back
  localparam int unsigned QDepthDef = 8;

  // item handed from front to back
  typedef struct packed {
    logic [Lanes-1:0][SQW-1:0] m2;
    logic [SQW-1:0]            nsq;
    logic [Lanes-1:0]          neg;
    logic                      zero;
  } qpn_item_t;

endpackage

[sv/qpn_front.sv]
module qpn_front
  import qpn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [15:0] a_x_i,
  input  logic signed [15:0] a_y_i,
  input  logic signed [15:0] a_z_i,
  input  logic signed [15:0] a_w_i,
  input  logic signed [15:0] b_x_i,
  input  logic signed [15:0] b_y_i,
  input  logic signed [15:0] b_z_i,
  input  logic signed [15:0] b_w_i,
  output logic               item_valid_o,
  output qpn_item_t          item_o
);

  logic [5:0] vld_q;

  logic signed [31:0]  prod_q [16];
  logic signed [PW-1:0] p_q   [Lanes];
  logic [MW-1:0]        mag_q [Lanes];
  logic [Lanes-1:0]     neg3_q, neg4_q, neg5_q;
  logic [31:0]          hh_q  [Lanes];
  logic [32:0]          hl_q  [Lanes];
  logic [33:0]          ll_q  [Lanes];
  logic [SQW-1:0]       m2_q  [Lanes];
  qpn_item_t            item_q;

  logic signed [PW-1:0] p_d   [Lanes];
  logic [SQW-1:0]       nsq_d;

  // component sums of the product and the squared norm
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      p_d[l] = PW'(prod_q[4*l]) + PW'(prod_q[4*l+1]) + PW'(prod_q[4*l+2])
             - PW'(prod_q[4*l+3]);
    end
    p_d[3] = PW'(prod_q[12]) - PW'(prod_q[13]) - PW'(prod_q[14]) - PW'(prod_q[15]);
    nsq_d = m2_q[0] + m2_q[1] + m2_q[2] + m2_q[3];
  end

  // stage valids, free running
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    // partial products
    prod_q[0]  <= a_w_i * b_x_i;
    prod_q[1]  <= b_w_i * a_x_i;
    prod_q[2]  <= b_y_i * a_z_i;
    prod_q[3]  <= b_z_i * a_y_i;
    prod_q[4]  <= a_w_i * b_y_i;
    prod_q[5]  <= b_w_i * a_y_i;
    prod_q[6]  <= b_z_i * a_x_i;
    prod_q[7]  <= b_x_i * a_z_i;
    prod_q[8]  <= a_w_i * b_z_i;
    prod_q[9]  <= b_w_i * a_z_i;
    prod_q[10] <= b_x_i * a_y_i;
    prod_q[11] <= b_y_i * a_x_i;
    prod_q[12] <= a_w_i * b_w_i;
    prod_q[13] <= a_x_i * b_x_i;
    prod_q[14] <= a_y_i * b_y_i;
    prod_q[15] <= a_z_i * b_z_i;
    for (int l = 0; l < Lanes; l++) begin
      p_q[l]    <= p_d[l];
      // magnitude and sign
      neg3_q[l] <= p_q[l][PW-1];
      mag_q[l]  <= p_q[l][PW-1] ? MW'(-p_q[l]) : MW'(p_q[l]);
      // split square of the magnitude
      hh_q[l]   <= mag_q[l][MW-1:MLW] * mag_q[l][MW-1:MLW];
      hl_q[l]   <= mag_q[l][MW-1:MLW] * mag_q[l][MLW-1:0];
      ll_q[l]   <= mag_q[l][MLW-1:0] * mag_q[l][MLW-1:0];
      m2_q[l]   <= (SQW'(hh_q[l]) << (2*MLW)) + (SQW'(hl_q[l]) << (MLW+1))
                 + SQW'(ll_q[l]);
      item_q.m2[l] <= m2_q[l];
    end
    neg4_q      <= neg3_q;
    neg5_q      <= neg4_q;
    // squared norm and zero class
    item_q.nsq  <= nsq_d;
    item_q.neg  <= neg5_q;
    item_q.zero <= (nsq_d == '0);
  end

  assign item_valid_o = vld_q[5];
  assign item_o       = item_q;

endmodule

[sv/qpn_queue.sv]
`include "assert_macros.svh"

module qpn_queue
  import qpn_pkg::*;
#(
  parameter int unsigned QDepth = QDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  qpn_item_t push_item_i,
  input  logic      pop_i,
  output logic      head_valid_o,
  output qpn_item_t head_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  qpn_item_t       mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    return (p == PtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= nxt(wr_ptr_q);
      if (pop_i) rd_ptr_q <= nxt(rd_ptr_q);
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_item_i;
  end

  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && !pop_i && (cnt_q == CntW'(QDepth)), "queue overflow")
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && (cnt_q == '0), "queue underflow")

endmodule

[sv/qpn_back.sv]
module qpn_back
  import qpn_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  qpn_item_t            head_i,
  output logic                 pop_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [OW-1:0] r_x_o,
  output logic signed [OW-1:0] r_y_o,
  output logic signed [OW-1:0] r_z_o,
  output logic signed [OW-1:0] r_w_o,
  output logic                 zero_norm_o
);

  localparam int unsigned Divs = QW;

  // division stages: remainder, quotient, side data
  logic [SQW-1:0]   dr_q [Divs][Lanes];
  logic [SQW-1:0]   dr_d [Divs][Lanes];
  logic [QW-1:0]    dq_q [Divs][Lanes];
  logic [QW-1:0]    dq_d [Divs][Lanes];
  logic [SQW-1:0]   dn_q [Divs];
  logic [SQW-1:0]   dn_d [Divs];
  logic [Lanes-1:0] ds_q [Divs];
  logic [Lanes-1:0] ds_d [Divs];
  logic             dz_q [Divs];
  logic             dz_d [Divs];
  logic [Divs-1:0]  dv_q;

  // square root stages: operand, root, side data
  logic [QW-1:0]    so_q [SQS][Lanes];
  logic [QW-1:0]    so_d [SQS][Lanes];
  logic [QW-1:0]    sr_q [SQS][Lanes];
  logic [QW-1:0]    sr_d [SQS][Lanes];
  logic [Lanes-1:0] ss_q [SQS];
  logic [Lanes-1:0] ss_d [SQS];
  logic             sz_q [SQS];
  logic             sz_d [SQS];
  logic [SQS-1:0]   sv_q;

  logic signed [OW-1:0] res_q [Lanes];
  logic signed [OW-1:0] res_d [Lanes];
  logic                 out_vld_q, zero_q;
  logic                 en;

  // whole pipeline advances when the output slot frees
  assign en    = !out_vld_q || ready_i;
  assign pop_o = en && head_valid_i;

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [SQW:0]   r;
    logic [SQW-1:0] n;
    logic [QW-1:0]  qi;
    for (int d = 0; d < Divs; d++) begin
      if (d == 0) begin
        n       = head_i.nsq;
        ds_d[d] = head_i.neg;
        dz_d[d] = head_i.zero;
      end else begin
        n       = dn_q[d-1];
        ds_d[d] = ds_q[d-1];
        dz_d[d] = dz_q[d-1];
      end
      dn_d[d] = n;
      for (int l = 0; l < Lanes; l++) begin
        if (d == 0) begin
          r  = {1'b0, head_i.m2[l]};
          qi = '0;
        end else begin
          r  = {dr_q[d-1][l], 1'b0};
          qi = dq_q[d-1][l];
        end
        if (r >= {1'b0, n}) begin
          dr_d[d][l] = SQW'(r - {1'b0, n});
          dq_d[d][l] = {qi[QW-2:0], 1'b1};
        end else begin
          dr_d[d][l] = SQW'(r);
          dq_d[d][l] = {qi[QW-2:0], 1'b0};
        end
      end
    end
  end

  // digit-by-digit square root, one root bit per stage
  always_comb begin
    logic [QW-1:0] op, rt, one;
    logic [QW:0]   t;
    for (int s = 0; s < SQS; s++) begin
      one = QW'(1) << (QW - 1 - 2*s);
      if (s == 0) begin
        ss_d[s] = ds_q[Divs-1];
        sz_d[s] = dz_q[Divs-1];
      end else begin
        ss_d[s] = ss_q[s-1];
        sz_d[s] = sz_q[s-1];
      end
      for (int l = 0; l < Lanes; l++) begin
        if (s == 0) begin
          op = dq_q[Divs-1][l];
          rt = '0;
        end else begin
          op = so_q[s-1][l];
          rt = sr_q[s-1][l];
        end
        t = {1'b0, rt} + {1'b0, one};
        if ({1'b0, op} >= t) begin
          so_d[s][l] = QW'({1'b0, op} - t);
          sr_d[s][l] = (rt >> 1) + one;
        end else begin
          so_d[s][l] = op;
          sr_d[s][l] = rt >> 1;
        end
      end
    end
  end

  // sign and zero handling
  always_comb begin
    logic [OW-1:0] v;
    for (int l = 0; l < Lanes; l++) begin
      v = {1'b0, sr_q[SQS-1][l][OW-2:0]};
      if (sz_q[SQS-1]) begin
        res_d[l] = '0;
      end else if (ss_q[SQS-1][l]) begin
        res_d[l] = -v;
      end else begin
        res_d[l] = v;
      end
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q      <= '0;
      sv_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      dv_q      <= {dv_q[Divs-2:0], head_valid_i};
      sv_q      <= {sv_q[SQS-2:0], dv_q[Divs-1]};
      out_vld_q <= sv_q[SQS-1];
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (en) begin
      dr_q   <= dr_d;
      dq_q   <= dq_d;
      dn_q   <= dn_d;
      ds_q   <= ds_d;
      dz_q   <= dz_d;
      so_q   <= so_d;
      sr_q   <= sr_d;
      ss_q   <= ss_d;
      sz_q   <= sz_d;
      res_q  <= res_d;
      zero_q <= sz_q[SQS-1];
    end
  end

  assign valid_o     = out_vld_q;
  assign r_x_o       = res_q[0];
  assign r_y_o       = res_q[1];
  assign r_z_o       = res_q[2];
  assign r_w_o       = res_q[3];
  assign zero_norm_o = zero_q;

endmodule

[sv/quaternion_product_normalize_top.sv]
// normalized quaternion product
// input beat: a_x/a_y/a_z/a_w and b_x/b_y/b_z/b_w, signed Q1.14, on
// in_valid_i / in_ready_o. output beat: r_x/r_y/r_z/r_w, signed Q1.14, the
// product a*b divided by its euclidean norm and truncated toward zero, plus
// zero_norm_o, on out_valid_o / out_ready_i. a zero product gives zero
// components with zero_norm_o set.
// throughput: one beat per cycle in both directions with the default QDepth
// and while the receiver does not stall. an accepted beat passes through the
// front (products, sums, magnitudes, split squares, squares, norm), the queue,
// the division pipeline (one quotient bit per stage), the square root pipeline
// (one root bit per stage) and the output register.
// when the receiver stalls, the back pipeline holds; the front keeps running
// into the queue and in_ready_o drops once QDepth beats are outstanding
// between input and back pipeline.
// reset clears the valids, the queue and the credit count, not the datapath.
`include "assert_macros.svh"

module quaternion_product_normalize_top
  import qpn_pkg::*;
#(
  parameter int unsigned QDepth = QDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [15:0]   a_x_i,
  input  logic signed [15:0]   a_y_i,
  input  logic signed [15:0]   a_z_i,
  input  logic signed [15:0]   a_w_i,
  input  logic signed [15:0]   b_x_i,
  input  logic signed [15:0]   b_y_i,
  input  logic signed [15:0]   b_z_i,
  input  logic signed [15:0]   b_w_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [OW-1:0] r_x_o,
  output logic signed [OW-1:0] r_y_o,
  output logic signed [OW-1:0] r_z_o,
  output logic signed [OW-1:0] r_w_o,
  output logic                 zero_norm_o
);

  localparam int unsigned CntW = $clog2(QDepth + 1);

  logic            in_acc, pop, item_valid, head_valid;
  qpn_item_t       item, head;
  logic [CntW-1:0] cred_q;

  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = (cred_q < CntW'(QDepth));

  // beats in front or queue, so the queue never overflows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= '0;
    end else begin
      cred_q <= cred_q + CntW'(in_acc) - CntW'(pop);
    end
  end

  qpn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_acc),
    .a_x_i        (a_x_i),
    .a_y_i        (a_y_i),
    .a_z_i        (a_z_i),
    .a_w_i        (a_w_i),
    .b_x_i        (b_x_i),
    .b_y_i        (b_y_i),
    .b_z_i        (b_z_i),
    .b_w_i        (b_w_i),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  qpn_queue #(
    .QDepth (QDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (item_valid),
    .push_item_i  (item),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  qpn_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .r_x_o        (r_x_o),
    .r_y_o        (r_y_o),
    .r_z_o        (r_z_o),
    .r_w_o        (r_w_o),
    .zero_norm_o  (zero_norm_o)
  );

  `ASSERT_NEVER(a_cred_bound, clk_i, rst_ni, cred_q > CntW'(QDepth), "credit count above queue depth")
  `ASSERT_CHK(a_zero_out, clk_i, rst_ni, (out_valid_o && zero_norm_o) |-> (r_x_o == '0 && r_y_o == '0 && r_z_o == '0 && r_w_o == '0), "zero norm with nonzero output")

endmodule

[dv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qpn_pkg::*;

  localparam int unsigned Latency = 52;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic signed [15:0] rx, ry, rz, rw;
    logic               zn;
  } qprod_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] a_x_i = '0, a_y_i = '0, a_z_i = '0, a_w_i = '0;
  logic signed [15:0] b_x_i = '0, b_y_i = '0, b_z_i = '0, b_w_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [OW-1:0] r_x_o, r_y_o, r_z_o, r_w_o;
  logic zero_norm_o;

  qprod_t expected_q[$];
  int errors = 0;
  longint cycles = 0;
  bit sink_stall_on = 1'b1;

  quaternion_product_normalize_top dut (.*);

  always #4 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("quaternion_product_normalize_top test failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // largest q <= 2^14 with q^2 * nsq <= m^2 * 2^28
  function automatic logic signed [15:0] scaled_div(longint p, logic [127:0] nsq);
    logic [127:0] m, rhs, q, c;
    m = (p < 0) ? 128'(-p) : 128'(p);
    rhs = (m * m) << 28;
    q = 0;
    for (int b = 14; b >= 0; b--) begin
      c = q | (128'd1 << b);
      if (nsq * c * c <= rhs) q = c;
    end
    return (p < 0) ? -q[15:0] : q[15:0];
  endfunction

  function automatic qprod_t normalized_product(logic signed [15:0] v[8]);
    longint ax, ay, az, aw, bx, by, bz, bw;
    longint p[4];
    logic [127:0] nsq;
    logic [127:0] m;
    qprod_t e;
    ax = v[0]; ay = v[1]; az = v[2]; aw = v[3];
    bx = v[4]; by = v[5]; bz = v[6]; bw = v[7];
    p[0] = aw * bx + bw * ax + (by * az - bz * ay);
    p[1] = aw * by + bw * ay + (bz * ax - bx * az);
    p[2] = aw * bz + bw * az + (bx * ay - by * ax);
    p[3] = aw * bw - (ax * bx + ay * by + az * bz);
    nsq = 0;
    // squares can reach 2^64, so square the magnitude at full width
    for (int i = 0; i < 4; i++) begin
      m = (p[i] < 0) ? 128'(-p[i]) : 128'(p[i]);
      nsq += m * m;
    end
    e.zn = (nsq == 0);
    e.rx = e.zn ? '0 : scaled_div(p[0], nsq);
    e.ry = e.zn ? '0 : scaled_div(p[1], nsq);
    e.rz = e.zn ? '0 : scaled_div(p[2], nsq);
    e.rw = e.zn ? '0 : scaled_div(p[3], nsq);
    return e;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  // send one beat, then an optional gap
  task automatic send_quats(logic signed [15:0] v[8], bit may_gap = 1'b1);
    int g;
    a_x_i <= v[0]; a_y_i <= v[1]; a_z_i <= v[2]; a_w_i <= v[3];
    b_x_i <= v[4]; b_y_i <= v[5]; b_z_i <= v[6]; b_w_i <= v[7];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(normalized_product(v));
    g = may_gap ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // sink stall pattern
  always @(posedge clk_i) begin
    if (!sink_stall_on) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 99) < 70);
  end

  // result checker
  always @(posedge clk_i) begin
    qprod_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        e = expected_q.pop_front();
        if (r_x_o !== e.rx) report("r_x", r_x_o, e.rx);
        if (r_y_o !== e.ry) report("r_y", r_y_o, e.ry);
        if (r_z_o !== e.rz) report("r_z", r_z_o, e.rz);
        if (r_w_o !== e.rw) report("r_w", r_w_o, e.rw);
        if (zero_norm_o !== e.zn) report("zero_norm", zero_norm_o, e.zn);
      end
    end
  end

  task automatic test_directed();
    logic signed [15:0] v[8];
    logic signed [15:0] corner[4] = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd16384};
    // all zero: zero norm
    v = '{default: 16'sd0};
    send_quats(v);
    // one side zero
    v = '{16'sd100, -16'sd5, 16'sd7, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    send_quats(v);
    // identity times identity: one component carries the norm
    v = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384};
    send_quats(v);
    // pure x times pure y
    v = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0};
    send_quats(v);
    // full-scale patterns
    for (int k = 0; k < 4; k++) begin
      v = '{default: corner[k]};
      send_quats(v);
    end
    v = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
    send_quats(v);
    v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
          16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    send_quats(v);
    // tiny inputs, small norm
    v = '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1};
    send_quats(v);
    v = '{-16'sd1, 16'sd1, -16'sd1, 16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1};
    send_quats(v);
  endtask

  task automatic test_random(int n, bit burst);
    logic signed [15:0] v[8];
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(0, 9);
      for (int j = 0; j < 8; j++) begin
        if (mode < 6) v[j] = 16'($urandom());
        else if (mode < 8) v[j] = $signed(16'($urandom_range(0, 16))) - 16'sd8;
        else v[j] = ($urandom_range(0, 3) == 0) ? 16'sd0 : 16'($urandom());
      end
      send_quats(v, !burst);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(500, 1'b0);
    // back-to-back with a free-running sink
    sink_stall_on = 1'b0;
    test_random(150, 1'b1);
    // back-to-back into a stalling sink
    sink_stall_on = 1'b1;
    test_random(150, 1'b1);
    drain();
    if (errors == 0) $display("quaternion_product_normalize_top test passed");
    else $display("quaternion_product_normalize_top test failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/qpn_pkg.sv
sv/qpn_front.sv
sv/qpn_queue.sv
sv/qpn_back.sv
sv/quaternion_product_normalize_top.sv
dv/testbench.sv
